>>> hw/rtl/knn_pixel_mask_classifier_macros.svh
// Assertion helpers for the kNN pixel mask classifier.
// Expect clk_i and rst_ni in the scope of use.
`ifndef KNN_PIXEL_MASK_CLASSIFIER_MACROS_SVH
`define KNN_PIXEL_MASK_CLASSIFIER_MACROS_SVH

// property checked on every rising clock edge outside reset
`define KNN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition that must never be seen
`define KNN_ASSERT_NEVER(label, cond, msg) \
  `KNN_ASSERT(label, !(cond), msg)

`endif

>>> hw/rtl/knn_pkg.sv
// Shared types and constants of the kNN pixel mask classifier.
// No dependencies; used by every RTL file of the block.
`default_nettype none

package knn_pkg;

  localparam int MAX_SAMPLES_DEF = 64;
  localparam int VOTE_MAX        = 127;
  localparam int CH_W            = 8;
  localparam int IDX_W           = 6;
  localparam int VOTE_W          = 7;
  localparam int CFG_W           = 7;
  localparam int CFG_IDX_W       = 1;
  localparam int SQ_W            = 16;   // (255)^2 fits in 16 bits
  localparam int DIST_W          = 18;   // sum of three squares
  localparam int S_TDATA_W       = 32;
  localparam int M_TDATA_W       = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEIGHBOUR_COUNT = 1'b0,
    REG_ACTIVE_SAMPLES  = 1'b1
  } knn_reg_e;

  typedef struct packed {
    logic            label;
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] c;
  } sample_t;

  // controller -> datapath
  typedef struct packed {
    logic load_wr;   // write a sample into the table
    logic start;     // latch pixel, clear neighbour list
    logic issue;     // read next table entry
    logic count;     // register group vote counts
    logic total;     // register vote totals
    logic load_out;  // move result into output register
  } knn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
    logic out_full;
  } knn_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/knn_pixel_mask_classifier.sv
// kNN pixel mask classifier, top level: ports, config registers, assertions.
// Depends on knn_pkg, knn_ctrl, knn_dp, knn_kbest and the macros header.
//
// Usage:
//   Input stream (s_axis_*): tuser[0] selects the kind of transfer.
//     0 = load: writes a labelled colour sample into table entry sample_index.
//         Gives no result; indices beyond the table are dropped.
//     1 = classify: a pixel; gives exactly one result transfer.
//   Output stream (m_axis_*): mask bit plus foreground and background vote counts.
//   Config port: cfg_we_i writes cfg_data_i into the register cfg_index_i
//     (0 neighbour_count, 1 active_samples); write only while the block is idle.
// Operation:
//   A classify keeps the input closed until its result is loaded: n table reads
//   (n = active samples, clipped to the table), one done check, the drain of the
//   distance pipeline, the group vote count, the vote total and the result load.
//   Load transfers go back to back.
// Reset: config registers return to 1, FSM idle, result register empty; the
//   sample table holds garbage until loaded.
// Stall: a result waits in the output register; the next item is still taken,
//   and a further classify holds before its result until the register drains.
`default_nettype none

`include "knn_pixel_mask_classifier_macros.svh"

module knn_pixel_mask_classifier #(
  parameter int MAX_SAMPLES = knn_pkg::MAX_SAMPLES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // s_axis_tdata: [5:0] sample_index, [13:6] channel_a, [21:14] channel_b,
  //               [29:22] channel_c, [30] sample_label, [31] zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [knn_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // s_axis_tuser: [0] mode
  input  logic [0:0]                      s_axis_tuser,
  // m_axis_tdata: [0] is_foreground, [7:1] foreground_votes,
  //               [14:8] background_votes, [15] zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [knn_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [knn_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [knn_pkg::CFG_W-1:0]       cfg_data_i
);
  import knn_pkg::*;

  // ---- config registers
  logic [CFG_W-1:0] neighbour_count_q, active_samples_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neighbour_count_q <= CFG_W'(1);
      active_samples_q  <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (knn_reg_e'(cfg_index_i))
        REG_NEIGHBOUR_COUNT: neighbour_count_q <= cfg_data_i;
        REG_ACTIVE_SAMPLES:  active_samples_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- controller and datapath
  knn_cmd_t    cmd;
  knn_status_t status;
  logic              res_is_fg;
  logic [VOTE_W-1:0] res_fg, res_bg;

  knn_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_mode_i  (s_axis_tuser[0]),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  knn_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .in_index_i        (s_axis_tdata[5:0]),
    .in_a_i            (s_axis_tdata[13:6]),
    .in_b_i            (s_axis_tdata[21:14]),
    .in_c_i            (s_axis_tdata[29:22]),
    .in_label_i        (s_axis_tdata[30]),
    .neighbour_count_i (neighbour_count_q),
    .active_samples_i  (active_samples_q),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_is_fg_o       (res_is_fg),
    .out_fg_votes_o    (res_fg),
    .out_bg_votes_o    (res_bg)
  );

  assign m_axis_tdata = {1'b0, res_bg, res_fg, res_is_fg};

  // ---- assertions
  // once a classify starts the input side stays closed during the scan
  `KNN_ASSERT(a_start_closes_input, cmd.start |=> !s_axis_tready, "input open during scan")
  // a pending result is never overwritten
  `KNN_ASSERT_NEVER(a_no_result_overwrite, cmd.load_out && status.out_full, "result overwritten")
  // votes are counted only after every distance has been inserted
  `KNN_ASSERT_NEVER(a_count_after_drain, cmd.count && status.pipe_busy, "count before drain")

endmodule

`default_nettype wire

>>> hw/rtl/knn_ctrl.sv
// Controller FSM of the kNN pixel mask classifier.
// Depends on knn_pkg; drives the datapath through knn_cmd_t.
`default_nettype none

module knn_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  logic                 s_mode_i,
  input  knn_pkg::knn_status_t status_i,
  output logic                 s_ready_o,
  output knn_pkg::knn_cmd_t    cmd_o
);
  import knn_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_COUNT  = 6'b001000,
    ST_TOTAL  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_wr = accept && !s_mode_i;
        cmd_o.start   = accept && s_mode_i;
        if (accept && s_mode_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.issue = !status_i.scan_done;
        if (status_i.scan_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        cmd_o.count = 1'b1;
        state_d     = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd_o.total = 1'b1;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.load_out = !status_i.out_full;
        if (!status_i.out_full) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/knn_kbest.sv
// Sorted k-best neighbour list, updated on each valid insertion.
// Depends on knn_pkg; instantiated by knn_dp.
`default_nettype none

module knn_kbest #(
  parameter int SLOTS = 64,
  parameter int K_W   = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       ins_valid_i,
  input  logic [knn_pkg::DIST_W-1:0] ins_dist_i,
  input  logic                       ins_label_i,
  input  logic [K_W-1:0]             k_i,
  output logic [SLOTS-1:0]           fg_o,
  output logic [SLOTS-1:0]           bg_o
);
  import knn_pkg::*;

  logic [DIST_W-1:0] dist_q [SLOTS];
  logic              lab_q  [SLOTS];
  logic              val_q  [SLOTS];
  logic              keep   [SLOTS];

  // Entries are visited in index order, so an older entry with an equal
  // distance stays ahead of the new one.
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    logic              cap, upd, pk, pv, pl;
    logic [DIST_W-1:0] pd;

    assign keep[s] = val_q[s] && (dist_q[s] <= ins_dist_i);
    assign cap     = k_i > K_W'(s);

    if (s == 0) begin : g_first
      assign pk = 1'b1;
      assign pv = 1'b0;
      assign pl = 1'b0;
      assign pd = '0;
    end else begin : g_rest
      assign pk = keep[s-1];
      assign pv = val_q[s-1];
      assign pl = lab_q[s-1];
      assign pd = dist_q[s-1];
    end

    assign upd = ins_valid_i && cap && !keep[s];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        val_q[s] <= 1'b0;
      end else if (clear_i) begin
        val_q[s] <= 1'b0;
      end else if (upd) begin
        val_q[s] <= pk | pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (upd) begin
        dist_q[s] <= pk ? ins_dist_i  : pd;
        lab_q[s]  <= pk ? ins_label_i : pl;
      end
    end

    assign fg_o[s] = val_q[s] &&  lab_q[s];
    assign bg_o[s] = val_q[s] && !lab_q[s];
  end

endmodule

`default_nettype wire

>>> hw/rtl/knn_dp.sv
// Datapath: sample table, distance pipeline, k-best list, vote tree, result register.
// Depends on knn_pkg and knn_kbest; commanded by knn_ctrl.
`default_nettype none

module knn_dp #(
  parameter int MAX_SAMPLES = knn_pkg::MAX_SAMPLES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  knn_pkg::knn_cmd_t           cmd_i,
  output knn_pkg::knn_status_t        status_o,
  input  logic [knn_pkg::IDX_W-1:0]   in_index_i,
  input  logic [knn_pkg::CH_W-1:0]    in_a_i,
  input  logic [knn_pkg::CH_W-1:0]    in_b_i,
  input  logic [knn_pkg::CH_W-1:0]    in_c_i,
  input  logic                        in_label_i,
  input  logic [knn_pkg::CFG_W-1:0]   neighbour_count_i,
  input  logic [knn_pkg::CFG_W-1:0]   active_samples_i,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_is_fg_o,
  output logic [knn_pkg::VOTE_W-1:0]  out_fg_votes_o,
  output logic [knn_pkg::VOTE_W-1:0]  out_bg_votes_o
);
  import knn_pkg::*;

  localparam int AW     = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CNT_W  = ($clog2(MAX_SAMPLES + 1) > CFG_W) ? $clog2(MAX_SAMPLES + 1) : CFG_W;
  localparam int SLOTS  = (MAX_SAMPLES < VOTE_MAX) ? MAX_SAMPLES : VOTE_MAX;
  localparam int GROUPS = (SLOTS + 7) / 8;
  localparam int GRP_W  = 4;

  // ---- effective counts
  logic [CNT_W-1:0] n_eff, k_eff, nc_ext, as_ext;
  assign nc_ext = CNT_W'(neighbour_count_i);
  assign as_ext = CNT_W'(active_samples_i);
  assign n_eff  = (as_ext > CNT_W'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : as_ext;
  assign k_eff  = (nc_ext > n_eff) ? n_eff : nc_ext;

  // ---- sample table
  sample_t sample_mem [MAX_SAMPLES];
  sample_t rd_q;
  logic    wr_en;
  logic [CNT_W-1:0] cnt_q;

  assign wr_en = cmd_i.load_wr && (CNT_W'(in_index_i) < CNT_W'(MAX_SAMPLES));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sample_mem[AW'(in_index_i)] <= '{label: in_label_i, a: in_a_i, b: in_b_i, c: in_c_i};
    end
    if (cmd_i.issue) begin
      rd_q <= sample_mem[cnt_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // ---- pixel latch
  logic [CH_W-1:0] px_a_q, px_b_q, px_c_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_a_q <= in_a_i;
      px_b_q <= in_b_i;
      px_c_q <= in_c_i;
    end
  end

  // ---- distance pipeline: table read, squares, sum
  logic rd_v_q, sq_v_q, sum_v_q;
  logic signed [CH_W:0]     da, db, dc;
  logic signed [2*CH_W+1:0] pa, pb, pc;
  logic [SQ_W-1:0]          sq_a_q, sq_b_q, sq_c_q;
  logic                     sq_lab_q, sum_lab_q;
  logic [DIST_W-1:0]        sum_q;

  assign da = $signed({1'b0, rd_q.a}) - $signed({1'b0, px_a_q});
  assign db = $signed({1'b0, rd_q.b}) - $signed({1'b0, px_b_q});
  assign dc = $signed({1'b0, rd_q.c}) - $signed({1'b0, px_c_q});
  assign pa = da * da;
  assign pb = db * db;
  assign pc = dc * dc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      sq_v_q  <= 1'b0;
      sum_v_q <= 1'b0;
    end else begin
      rd_v_q  <= cmd_i.issue;
      sq_v_q  <= rd_v_q;
      sum_v_q <= sq_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_a_q    <= pa[SQ_W-1:0];
    sq_b_q    <= pb[SQ_W-1:0];
    sq_c_q    <= pc[SQ_W-1:0];
    sq_lab_q  <= rd_q.label;
    sum_q     <= DIST_W'(sq_a_q) + DIST_W'(sq_b_q) + DIST_W'(sq_c_q);
    sum_lab_q <= sq_lab_q;
  end

  // ---- neighbour list
  logic [SLOTS-1:0] fg_bits, bg_bits;

  knn_kbest #(
    .SLOTS (SLOTS),
    .K_W   (CNT_W)
  ) u_kbest (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cmd_i.start),
    .ins_valid_i (sum_v_q),
    .ins_dist_i  (sum_q),
    .ins_label_i (sum_lab_q),
    .k_i         (k_eff),
    .fg_o        (fg_bits),
    .bg_o        (bg_bits)
  );

  // ---- vote tree: groups of eight, then total
  logic [GROUPS*8-1:0] fg_pad, bg_pad;
  logic [GRP_W-1:0]    grp_fg_d [GROUPS];
  logic [GRP_W-1:0]    grp_bg_d [GROUPS];
  logic [GRP_W-1:0]    grp_fg_q [GROUPS];
  logic [GRP_W-1:0]    grp_bg_q [GROUPS];
  logic [VOTE_W-1:0]   tot_fg_d, tot_bg_d, tot_fg_q, tot_bg_q;

  assign fg_pad = (GROUPS*8)'(fg_bits);
  assign bg_pad = (GROUPS*8)'(bg_bits);

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_fg_d[g] = '0;
      grp_bg_d[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_fg_d[g] = grp_fg_d[g] + GRP_W'(fg_pad[g*8+b]);
        grp_bg_d[g] = grp_bg_d[g] + GRP_W'(bg_pad[g*8+b]);
      end
    end
  end

  always_comb begin
    tot_fg_d = '0;
    tot_bg_d = '0;
    for (int g = 0; g < GROUPS; g++) begin
      tot_fg_d = tot_fg_d + VOTE_W'(grp_fg_q[g]);
      tot_bg_d = tot_bg_d + VOTE_W'(grp_bg_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.count) begin
      grp_fg_q <= grp_fg_d;
      grp_bg_q <= grp_bg_d;
    end
    if (cmd_i.total) begin
      tot_fg_q <= tot_fg_d;
      tot_bg_q <= tot_bg_d;
    end
  end

  // ---- result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_is_fg_o    <= !(tot_bg_q > tot_fg_q);
      out_fg_votes_o <= tot_fg_q;
      out_bg_votes_o <= tot_bg_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.scan_done = (cnt_q >= n_eff);
  assign status_o.pipe_busy = rd_v_q || sq_v_q || sum_v_q;
  assign status_o.out_full  = out_valid_q;

endmodule

`default_nettype wire

>>> verif/tb_knn_pixel_mask_classifier.sv
// Self-checking testbench for the kNN pixel mask classifier: loads labelled colour samples,
// classifies pixels under many k / sample-count settings and checks every mask transfer.
// Depends on knn_pkg and the knn_pixel_mask_classifier RTL.
`timescale 1ns / 1ps

module tb_knn_pixel_mask_classifier;
  import knn_pkg::*;

  localparam int TABLE_DEPTH     = MAX_SAMPLES_DEF;
  localparam int LATENCY_CYCLES  = 80;    // settle wait, longer than a full-table classify
  localparam int HOLD_OFF_CYCLES = 400;   // long sink stall, fills the block
  localparam int STALL_LIMIT     = 4000;  // cycles without any transfer
  localparam int ITEM_TARGET     = 1050;
  localparam int PHASE_ITEMS     = 80;
  localparam int LOAD_PCT        = 35;
  localparam int MAX_PRINTED     = 40;
  localparam int MAX_GAP         = 17;

  // first random settings: extremes of k and of the active sample count
  localparam int unsigned K_PLAN [8] = '{64, 1, 127, 0, 127, 5, 2, 33};
  localparam int unsigned N_PLAN [8] = '{64, 64, 127, 127, 1, 0, 3, 64};

  // s_axis_tuser[0]
  typedef enum logic {
    MODE_LOAD     = 1'b0,
    MODE_CLASSIFY = 1'b1
  } item_mode_e;

  typedef struct packed {
    logic              is_fg;
    logic [VOTE_W-1:0] fg_votes;
    logic [VOTE_W-1:0] bg_votes;
  } mask_result_t;

  // Shadow copy of the sample table and config; predicts one mask per classify
  // and checks mask transfers in order.
  class mask_scoreboard;
    sample_t      samples [TABLE_DEPTH];
    int unsigned  neighbour_cfg;
    int unsigned  active_cfg;
    mask_result_t expected_masks [$];
    int unsigned  errors;

    function new();
      neighbour_cfg = 1;
      active_cfg    = 1;
      errors        = 0;
      foreach (samples[i]) samples[i] = '0;
    endfunction

    function void set_reg(knn_reg_e idx, logic [CFG_W-1:0] value);
      if (idx == REG_NEIGHBOUR_COUNT) neighbour_cfg = value;
      else active_cfg = value;
    endfunction

    function int unsigned pending();
      return expected_masks.size();
    endfunction

    // k nearest by squared colour distance, lower index wins a tie
    function mask_result_t predict_votes(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                         logic [CH_W-1:0] c);
      int unsigned  dist_sq [TABLE_DEPTH];
      int unsigned  n_use, k_use, rank, fg, bg;
      int           da, db, dc;
      mask_result_t r;
      n_use = (active_cfg > TABLE_DEPTH) ? TABLE_DEPTH : active_cfg;
      k_use = (neighbour_cfg > n_use) ? n_use : neighbour_cfg;
      fg = 0;
      bg = 0;
      for (int i = 0; i < n_use; i++) begin
        da = int'(samples[i].a) - int'(a);
        db = int'(samples[i].b) - int'(b);
        dc = int'(samples[i].c) - int'(c);
        dist_sq[i] = da * da + db * db + dc * dc;
      end
      for (int i = 0; i < n_use; i++) begin
        rank = 0;
        for (int j = 0; j < n_use; j++)
          if (dist_sq[j] < dist_sq[i] || (dist_sq[j] == dist_sq[i] && j < i)) rank++;
        if (rank < k_use) begin
          if (samples[i].label) fg++;
          else bg++;
        end
      end
      r.is_fg    = (bg > fg) ? 1'b0 : 1'b1;
      r.fg_votes = VOTE_W'((fg > VOTE_MAX) ? VOTE_MAX : fg);
      r.bg_votes = VOTE_W'((bg > VOTE_MAX) ? VOTE_MAX : bg);
      return r;
    endfunction

    function void note_item(item_mode_e mode, logic [IDX_W-1:0] idx, sample_t s);
      if (mode == MODE_LOAD) samples[idx] = s;
      else expected_masks.push_back(predict_votes(s.a, s.b, s.c));
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_mask(logic [M_TDATA_W-1:0] data);
      mask_result_t want;
      mask_result_t got;
      if (expected_masks.size() == 0) begin
        report($sformatf("mask transfer 0x%04h with no classify pending", data));
        return;
      end
      want = expected_masks.pop_front();
      got  = {data[0], data[7:1], data[14:8]};
      if (got.is_fg !== want.is_fg)
        report($sformatf("is_foreground %0b, want %0b", got.is_fg, want.is_fg));
      if (got.fg_votes !== want.fg_votes)
        report($sformatf("foreground_votes %0d, want %0d", got.fg_votes, want.fg_votes));
      if (got.bg_votes !== want.bg_votes)
        report($sformatf("background_votes %0d, want %0d", got.bg_votes, want.bg_votes));
      if (data[M_TDATA_W-1] !== 1'b0)
        report("m_axis_tdata pad bit not zero");
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Block ports, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_W-1:0]      cfg_data_i    = '0;

  // idling knobs, changed per phase by the stimulus sequence
  bit          send_gaps_on     = 1'b1;
  bit          recv_gaps_on     = 1'b1;
  bit          hold_off_pending = 1'b0;
  int unsigned items_sent       = 0;
  int unsigned idle_cycles      = 0;

  mask_scoreboard board;

  knn_pixel_mask_classifier DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic sample_t mk_sample(logic label, logic [CH_W-1:0] a,
                                        logic [CH_W-1:0] b, logic [CH_W-1:0] c);
    sample_t s;
    s.label = label;
    s.a     = a;
    s.b     = b;
    s.c     = c;
    return s;
  endfunction

  // colour levels biased to the rails and mid-scale so equal distances happen often
  function automatic logic [CH_W-1:0] draw_level();
    case ($urandom_range(0, 3))
      0:       return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      1:       return CH_W'($urandom_range(126, 130));
      default: return CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic sample_t random_sample();
    return mk_sample(1'($urandom_range(0, 1)), draw_level(), draw_level(), draw_level());
  endfunction

  // One input transfer. tvalid stays high afterwards so back-to-back items keep
  // a single NBA per edge; it drops only on a gap or in settle().
  task automatic send_item(item_mode_e mode, logic [IDX_W-1:0] idx, sample_t s);
    int unsigned gap;
    gap = send_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    // tdata: idx, a, b, c, label, zero pad (low to high)
    s_axis_tdata  <= {1'b0, s.label, s.c, s.b, s.a, idx};
    s_axis_tuser  <= mode;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    board.note_item(mode, idx, s);
    items_sent++;
  endtask

  task automatic send_random();
    item_mode_e mode;
    mode = ($urandom_range(0, 99) < LOAD_PCT) ? MODE_LOAD : MODE_CLASSIFY;
    send_item(mode, IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), random_sample());
  endtask

  // Stop offering, wait for every pending mask, then let the block go quiet
  // (a trailing load gives no result to wait on).
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (LATENCY_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(knn_reg_e idx, logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned k, int unsigned n);
    settle();
    write_reg(REG_NEIGHBOUR_COUNT, CFG_W'(k));
    write_reg(REG_ACTIVE_SAMPLES, CFG_W'(n));
  endtask

  // ---------------------------------------------------------------------------
  // Mask sink: random tready gaps, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : mask_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_off_pending) begin
        gap = HOLD_OFF_CYCLES;
        hold_off_pending = 1'b0;
      end else begin
        gap = recv_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      board.check_mask(m_axis_tdata);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer on either stream
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL knn_pixel_mask_classifier");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k, n, j, tmp;
    int unsigned order [TABLE_DEPTH];

    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Samples 1 and 2 share a colour with opposite labels to
    // exercise the lower-index tie break.
    send_item(MODE_LOAD, 6'd0,  mk_sample(1'b1, 8'd255, 8'd255, 8'd255));
    send_item(MODE_LOAD, 6'd1,  mk_sample(1'b0, 8'd0,   8'd0,   8'd0));
    send_item(MODE_LOAD, 6'd2,  mk_sample(1'b1, 8'd0,   8'd0,   8'd0));
    send_item(MODE_LOAD, 6'd3,  mk_sample(1'b0, 8'd128, 8'd128, 8'd128));
    send_item(MODE_LOAD, 6'd63, mk_sample(1'b1, 8'd255, 8'd0,   8'd255));
    // reset settings: k = 1 over sample 0 only
    send_item(MODE_CLASSIFY, 6'd63, mk_sample(1'b1, 8'd0,   8'd0,   8'd0));
    send_item(MODE_CLASSIFY, 6'd0,  mk_sample(1'b0, 8'd255, 8'd255, 8'd255));
    // zero k: no votes, foreground
    set_config(0, 4);
    send_item(MODE_CLASSIFY, 6'd5, mk_sample(1'b0, 8'd10, 8'd20, 8'd30));
    // no active samples
    set_config(5, 0);
    send_item(MODE_CLASSIFY, 6'd9, mk_sample(1'b1, 8'd200, 8'd100, 8'd50));
    // k = 1, exact tie between samples 1 and 2 -> sample 1 (background)
    set_config(1, 4);
    send_item(MODE_CLASSIFY, 6'd0, mk_sample(1'b0, 8'd0,   8'd0,   8'd0));
    send_item(MODE_CLASSIFY, 6'd0, mk_sample(1'b0, 8'd128, 8'd128, 8'd128));
    // k = 2: vote tie goes foreground
    set_config(2, 4);
    send_item(MODE_CLASSIFY, 6'd0, mk_sample(1'b0, 8'd0,   8'd0,   8'd0));
    send_item(MODE_CLASSIFY, 6'd0, mk_sample(1'b0, 8'd255, 8'd255, 8'd255));
    // k = 3: background strictly wins
    set_config(3, 4);
    send_item(MODE_CLASSIFY, 6'd0, mk_sample(1'b0, 8'd0, 8'd0, 8'd0));
    // k far above the sample count is clipped
    set_config(127, 4);
    send_item(MODE_CLASSIFY, 6'd0, mk_sample(1'b0, 8'd128, 8'd128, 8'd128));
    send_item(MODE_CLASSIFY, 6'd0, mk_sample(1'b0, 8'd1,   8'd2,   8'd3));

    // Fill the whole table in shuffled order so any active count reads only
    // written entries from here on.
    foreach (order[i]) order[i] = i;
    for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    foreach (order[i]) send_item(MODE_LOAD, IDX_W'(order[i]), random_sample());

    // Random phases: planned extremes first, then mostly small settings.
    for (int p = 0; items_sent < ITEM_TARGET; p++) begin
      if (p < 8) begin
        k = K_PLAN[p];
        n = N_PLAN[p];
      end else begin
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 9);
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 20);
      end
      set_config(k, n);
      if (p == 0) begin
        // full-rate stretch on both sides
        send_gaps_on = 1'b0;
        recv_gaps_on = 1'b0;
      end else begin
        send_gaps_on = ($urandom_range(0, 3) != 0);
        recv_gaps_on = ($urandom_range(0, 3) != 0);
      end
      // sink backs off for a long stretch while items keep coming
      if (p == 2) hold_off_pending = 1'b1;
      repeat (PHASE_ITEMS) send_random();
    end

    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS knn_pixel_mask_classifier");
    end else begin
      $display("FAIL knn_pixel_mask_classifier");
    end
    $finish;
  end

endmodule
